FILE: src/bresenham_line_pixel_generator_core_defines.svh
// ----------------------------------------------------------------------------
// Bresenham line pixel generator assertion macros
// Shared assertion forms for the checker of the line walker.
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_PIXEL_GENERATOR_CORE_DEFINES_SVH
`define BRESENHAM_LINE_PIXEL_GENERATOR_CORE_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent, checked outside reset.
`define BLPG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent, also across reset.
`define BLPG_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/blpg_pkg.sv
// ----------------------------------------------------------------------------
// Bresenham line pixel generator package
// Widths, command codes, the queued command word and coordinate helpers.
// ----------------------------------------------------------------------------
package blpg_pkg;

  // Image and datapath widths.
  localparam int ImageSize = 512;
  localparam int CoordW    = 9;
  localparam int ColorW    = 8;
  localparam int MinorW    = 10;
  localparam int SpanW     = 10;
  localparam int StepW     = 11;
  localparam int AccW      = 12;

  // Command queue depth between the front and the back.
  localparam int FifoDepth = 2;
  localparam int PtrW      = $clog2(FifoDepth);

  // Word opcodes.
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_t;

  // Classified command word, with line setup already worked out for loads.
  typedef struct packed {
    op_t                   op;
    logic                  steep;
    logic [CoordW-1:0]     major_pos;
    logic [CoordW-1:0]     major_end;
    logic [CoordW-1:0]     minor_pos;
    logic                  minor_down;
    logic [SpanW-1:0]      major_span;
    logic [StepW-1:0]      error_step;
    logic [3*ColorW-1:0]   color;
  } cmd_t;

  // Clamp a coordinate to the last pixel of the image.
  function automatic logic [CoordW-1:0] sat_coord(input logic [CoordW-1:0] c);
    logic [CoordW-1:0] r;
    r = c;
    if (int'(c) > ImageSize - 1) begin
      r = CoordW'(ImageSize - 1);
    end
    return r;
  endfunction

  // Absolute difference of two coordinates.
  function automatic logic [CoordW-1:0] abs_diff(input logic [CoordW-1:0] a,
                                                 input logic [CoordW-1:0] b);
    logic [CoordW-1:0] r;
    if (a >= b) begin
      r = a - b;
    end else begin
      r = b - a;
    end
    return r;
  endfunction

endpackage

FILE: src/blpg_front.sv
// ----------------------------------------------------------------------------
// Bresenham line front end
// Accepts input words, decodes the opcode and prepares line setup on loads.
// ----------------------------------------------------------------------------
module blpg_front (
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [8:0]                    in_start_x,
  input  logic [8:0]                    in_start_y,
  input  logic [8:0]                    in_end_x,
  input  logic [8:0]                    in_end_y,
  input  logic [7:0]                    in_red_in,
  input  logic [7:0]                    in_green_in,
  input  logic [7:0]                    in_blue_in,
  output logic                          cmd_valid,
  input  logic                          cmd_ready,
  output blpg_pkg::cmd_t                cmd
);
  import blpg_pkg::*;

  logic [CoordW-1:0] ax, ay, bx, by;
  logic [CoordW-1:0] dx, dy;
  logic              steep;
  logic [CoordW-1:0] p0_maj, p0_min, p1_maj, p1_min;
  logic [CoordW-1:0] s_maj, s_min, e_maj, e_min;
  logic [CoordW-1:0] d_min;

  // Clamp the endpoints and decide whether the line is steep.
  always_comb begin
    ax    = sat_coord(in_start_x);
    ay    = sat_coord(in_start_y);
    bx    = sat_coord(in_end_x);
    by    = sat_coord(in_end_y);
    dx    = abs_diff(ax, bx);
    dy    = abs_diff(ay, by);
    steep = (dx < dy);
  end

  // Map onto major and minor axes, then order along the major axis.
  always_comb begin
    p0_maj = steep ? ay : ax;
    p0_min = steep ? ax : ay;
    p1_maj = steep ? by : bx;
    p1_min = steep ? bx : by;
    if (p0_maj > p1_maj) begin
      s_maj = p1_maj;
      s_min = p1_min;
      e_maj = p0_maj;
      e_min = p0_min;
    end else begin
      s_maj = p0_maj;
      s_min = p0_min;
      e_maj = p1_maj;
      e_min = p1_min;
    end
    d_min = abs_diff(s_min, e_min);
  end

  // Build the command word for the queue.
  always_comb begin
    cmd.op         = op_t'(in_op);
    cmd.steep      = steep;
    cmd.major_pos  = s_maj;
    cmd.major_end  = e_maj;
    cmd.minor_pos  = s_min;
    cmd.minor_down = (e_min < s_min);
    cmd.major_span = {1'b0, e_maj - s_maj};
    cmd.error_step = {1'b0, d_min, 1'b0};
    cmd.color      = {in_red_in, in_green_in, in_blue_in};
  end

  assign cmd_valid = in_valid;
  assign in_ready  = cmd_ready;

endmodule

FILE: src/blpg_fifo.sv
// ----------------------------------------------------------------------------
// Bresenham line command queue
// Small register queue that decouples the front end from the line walker.
// ----------------------------------------------------------------------------
module blpg_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  blpg_pkg::cmd_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output blpg_pkg::cmd_t rd_data
);
  import blpg_pkg::*;

  cmd_t            mem_r [FifoDepth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PtrW:0]   count_r, count_nxt;
  logic            push, pop;

  // Handshake decode.
  assign wr_ready = (count_r != (PtrW+1)'(FifoDepth));
  assign rd_valid = (count_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PtrW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + PtrW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (PtrW+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage write; entries carry no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

FILE: src/blpg_back.sv
// ----------------------------------------------------------------------------
// Bresenham line walker
// Holds the line state, steps the error term and registers each pixel word.
// ----------------------------------------------------------------------------
module blpg_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  blpg_pkg::cmd_t cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [8:0]     out_pixel_x,
  output logic [8:0]     out_pixel_y,
  output logic [7:0]     out_red_out,
  output logic [7:0]     out_green_out,
  output logic [7:0]     out_blue_out,
  output logic           out_last
);
  import blpg_pkg::*;

  // Line state.
  logic                    active_r, active_nxt;
  logic                    steep_r, steep_nxt;
  logic [CoordW-1:0]       major_pos_r, major_pos_nxt;
  logic [CoordW-1:0]       major_end_r, major_end_nxt;
  logic [MinorW-1:0]       minor_pos_r, minor_pos_nxt;
  logic                    minor_down_r, minor_down_nxt;
  logic [SpanW-1:0]        major_span_r, major_span_nxt;
  logic [StepW-1:0]        error_step_r, error_step_nxt;
  logic signed [AccW-1:0]  error_acc_r, error_acc_nxt;
  logic [3*ColorW-1:0]     color_r, color_nxt;

  // Output register.
  logic                    out_valid_r, out_valid_nxt;
  logic [CoordW-1:0]       out_px_r, out_px_nxt;
  logic [CoordW-1:0]       out_py_r, out_py_nxt;
  logic [3*ColorW-1:0]     out_color_r, out_color_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    slot_free, fire, emit, fin, acc_wrap;
  logic signed [AccW-1:0]  acc_sum;

  // A load or an idle step never needs the output slot.
  assign slot_free = !out_valid_r || out_ready;
  assign cmd_ready = (cmd.op == OP_LOAD) || !active_r || slot_free;
  assign fire      = cmd_valid && cmd_ready;
  assign emit      = fire && (cmd.op == OP_STEP) && active_r;

  // Error term for the current step.
  assign fin      = (major_pos_r >= major_end_r);
  assign acc_sum  = error_acc_r + $signed({1'b0, error_step_r});
  assign acc_wrap = (acc_sum > $signed({2'b0, major_span_r}));

  // Walker next state.
  always_comb begin
    active_nxt     = active_r;
    steep_nxt      = steep_r;
    major_pos_nxt  = major_pos_r;
    major_end_nxt  = major_end_r;
    minor_pos_nxt  = minor_pos_r;
    minor_down_nxt = minor_down_r;
    major_span_nxt = major_span_r;
    error_step_nxt = error_step_r;
    error_acc_nxt  = error_acc_r;
    color_nxt      = color_r;
    if (fire) begin
      case (cmd.op)
        OP_LOAD: begin
          active_nxt     = 1'b1;
          steep_nxt      = cmd.steep;
          major_pos_nxt  = cmd.major_pos;
          major_end_nxt  = cmd.major_end;
          minor_pos_nxt  = {1'b0, cmd.minor_pos};
          minor_down_nxt = cmd.minor_down;
          major_span_nxt = cmd.major_span;
          error_step_nxt = cmd.error_step;
          error_acc_nxt  = '0;
          color_nxt      = cmd.color;
        end
        OP_STEP: begin
          if (active_r) begin
            if (fin) begin
              active_nxt = 1'b0;
            end else begin
              error_acc_nxt = acc_sum;
              if (acc_wrap) begin
                minor_pos_nxt = minor_down_r ? minor_pos_r - MinorW'(1)
                                             : minor_pos_r + MinorW'(1);
                error_acc_nxt = acc_sum - $signed({1'b0, major_span_r, 1'b0});
              end
              major_pos_nxt = major_pos_r + CoordW'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Output register next state; axes are swapped back for steep lines.
  always_comb begin
    out_px_nxt    = out_px_r;
    out_py_nxt    = out_py_r;
    out_color_nxt = out_color_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_px_nxt    = steep_r ? minor_pos_r[CoordW-1:0] : major_pos_r;
      out_py_nxt    = steep_r ? major_pos_r : minor_pos_r[CoordW-1:0];
      out_color_nxt = color_r;
      out_last_nxt  = fin;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath state.
  always_ff @(posedge clk) begin
    steep_r      <= steep_nxt;
    major_pos_r  <= major_pos_nxt;
    major_end_r  <= major_end_nxt;
    minor_pos_r  <= minor_pos_nxt;
    minor_down_r <= minor_down_nxt;
    major_span_r <= major_span_nxt;
    error_step_r <= error_step_nxt;
    error_acc_r  <= error_acc_nxt;
    color_r      <= color_nxt;
    out_px_r     <= out_px_nxt;
    out_py_r     <= out_py_nxt;
    out_color_r  <= out_color_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_x   = out_px_r;
  assign out_pixel_y   = out_py_r;
  assign out_red_out   = out_color_r[3*ColorW-1:2*ColorW];
  assign out_green_out = out_color_r[2*ColorW-1:ColorW];
  assign out_blue_out  = out_color_r[ColorW-1:0];
  assign out_last      = out_last_r;

endmodule

FILE: src/bresenham_line_pixel_generator_core.sv
// A step word's pixel is registered in the queue and then in the output register before
// it can be taken by the output side.
// Throughput: one word per cycle; the walker retires one queued word each cycle while the
// output side takes words, and so sustains a pixel per cycle.
// Loads are taken by the walker without waiting for the output slot and produce no output word.
// Reset (rst_n low, synchronous) empties the queue, drops any line and the pending pixel.
// ----------------------------------------------------------------------------
// Bresenham line pixel generator core
// Front end decodes words, a two-entry queue buffers them, the walker emits pixels.
// ----------------------------------------------------------------------------
module bresenham_line_pixel_generator_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_op,
  input  logic [8:0] in_start_x,
  input  logic [8:0] in_start_y,
  input  logic [8:0] in_end_x,
  input  logic [8:0] in_end_y,
  input  logic [7:0] in_red_in,
  input  logic [7:0] in_green_in,
  input  logic [7:0] in_blue_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [8:0] out_pixel_x,
  output logic [8:0] out_pixel_y,
  output logic [7:0] out_red_out,
  output logic [7:0] out_green_out,
  output logic [7:0] out_blue_out,
  output logic       out_last
);
  import blpg_pkg::*;

  logic cmd_in_valid, cmd_in_ready;
  logic cmd_out_valid, cmd_out_ready;
  cmd_t cmd_in, cmd_out;

  // Decode and line setup.
  blpg_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_op       (in_op),
    .in_start_x  (in_start_x),
    .in_start_y  (in_start_y),
    .in_end_x    (in_end_x),
    .in_end_y    (in_end_y),
    .in_red_in   (in_red_in),
    .in_green_in (in_green_in),
    .in_blue_in  (in_blue_in),
    .cmd_valid   (cmd_in_valid),
    .cmd_ready   (cmd_in_ready),
    .cmd         (cmd_in)
  );

  // Command queue.
  blpg_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cmd_in_valid),
    .wr_ready (cmd_in_ready),
    .wr_data  (cmd_in),
    .rd_valid (cmd_out_valid),
    .rd_ready (cmd_out_ready),
    .rd_data  (cmd_out)
  );

  // Line walker and output register.
  blpg_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd_out_valid),
    .cmd_ready     (cmd_out_ready),
    .cmd           (cmd_out),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_x   (out_pixel_x),
    .out_pixel_y   (out_pixel_y),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out),
    .out_last      (out_last)
  );

endmodule

FILE: src/blpg_checker.sv
// ----------------------------------------------------------------------------
// Bresenham line pixel generator checker
// Port-level checks on reset behavior and output word stability.
// ----------------------------------------------------------------------------
`include "bresenham_line_pixel_generator_core_defines.svh"

module blpg_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [8:0] out_pixel_x,
  input logic [8:0] out_pixel_y,
  input logic       out_last
);

  // A stalled output word stays put.
  `BLPG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_pixel_x) && $stable(out_pixel_y) && $stable(out_last), "output word changed while stalled")

  // Reset leaves no pending pixel.
  `BLPG_ASSERT_NEXT_ALWAYS(a_rst_out_idle, !rst_n, !out_valid, "output valid right after reset")

  // Reset empties the queue, so a word can be taken at once.
  `BLPG_ASSERT_NEXT_ALWAYS(a_rst_in_ready, !rst_n, in_ready, "input not ready right after reset")

endmodule

bind bresenham_line_pixel_generator_core blpg_checker u_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_pixel_x (out_pixel_x),
  .out_pixel_y (out_pixel_y),
  .out_last    (out_last)
);
